>>> sv/tl_pkg.sv
// Shared types, token and error codes, and character helpers of the token lexer.
package tl_pkg;

	localparam int OFFSET_BITS = 24;
	localparam int FIELD_BITS = 24;
	localparam logic [FIELD_BITS-1:0] LEN_MAX = {FIELD_BITS{1'b1}};

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_END = 1'b1;

	localparam logic [4:0] KIND_END = 5'd0;
	localparam logic [4:0] KIND_ASSIGN = 5'd1;
	localparam logic [4:0] KIND_NUMBER = 5'd2;
	localparam logic [4:0] KIND_STRING = 5'd3;
	localparam logic [4:0] KIND_IDENT = 5'd4;
	localparam logic [4:0] KIND_IF = 5'd5;
	localparam logic [4:0] KIND_ELSE = 5'd6;
	localparam logic [4:0] KIND_LPAREN = 5'd7;
	localparam logic [4:0] KIND_RPAREN = 5'd8;
	localparam logic [4:0] KIND_LBRACE = 5'd9;
	localparam logic [4:0] KIND_RBRACE = 5'd10;
	localparam logic [4:0] KIND_LBRACKET = 5'd11;
	localparam logic [4:0] KIND_RBRACKET = 5'd12;
	localparam logic [4:0] KIND_PLUS = 5'd13;
	localparam logic [4:0] KIND_MINUS = 5'd14;
	localparam logic [4:0] KIND_SLASH = 5'd15;
	localparam logic [4:0] KIND_EQUAL = 5'd16;
	localparam logic [4:0] KIND_STAR = 5'd17;
	localparam logic [4:0] KIND_FUNCTION = 5'd18;
	localparam logic [4:0] KIND_SEMI = 5'd19;
	localparam logic [4:0] KIND_COMMA = 5'd20;
	localparam logic [4:0] KIND_LT = 5'd21;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_DOTTED_IDENT = 3'd1;
	localparam logic [2:0] ERR_EXTRA_DOTS = 3'd2;
	localparam logic [2:0] ERR_BAD_CHAR = 3'd3;
	localparam logic [2:0] ERR_OPEN_STRING = 3'd4;

	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_DOT = 8'h2E;

	typedef struct packed {
		logic action;
		logic [7:0] ch;
	} src_beat_t;

	typedef struct packed {
		logic [4:0] kind;
		logic [FIELD_BITS-1:0] start_offset;
		logic [FIELD_BITS-1:0] length;
		logic [2:0] error_code;
		logic last;
	} tok_beat_t;

	typedef struct packed {
		logic [1:0] count;
		tok_beat_t first;
		tok_beat_t second;
	} tl_emit_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] len;
		logic [1:0] dots;
		logic saw_letter;
		logic [2:0] alive;
	} word_t;

	localparam word_t WORD_RESET = '{len: '0, dots: 2'd0, saw_letter: 1'b0, alive: 3'b111};

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_word_char(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == CH_DOT;
	endfunction

	function automatic logic [4:0] punct_kind(input logic [7:0] c);
		logic [4:0] k;
		case (c)
			8'h28: k = KIND_LPAREN;
			8'h29: k = KIND_RPAREN;
			8'h7B: k = KIND_LBRACE;
			8'h7D: k = KIND_RBRACE;
			8'h5B: k = KIND_LBRACKET;
			8'h5D: k = KIND_RBRACKET;
			8'h2B: k = KIND_PLUS;
			8'h2D: k = KIND_MINUS;
			8'h2F: k = KIND_SLASH;
			8'h3D: k = KIND_EQUAL;
			8'h2A: k = KIND_STAR;
			8'h3B: k = KIND_SEMI;
			8'h2C: k = KIND_COMMA;
			default: k = KIND_END;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] kw_if_char(input logic [2:0] i);
		return i[0] ? 8'h66 : 8'h69;
	endfunction

	function automatic logic [7:0] kw_else_char(input logic [2:0] i);
		logic [7:0] c;
		case (i[1:0])
			2'd0: c = 8'h65;
			2'd1: c = 8'h6C;
			2'd2: c = 8'h73;
			default: c = 8'h65;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] kw_fun_char(input logic [2:0] i);
		logic [7:0] c;
		case (i)
			3'd0: c = 8'h66;
			3'd1: c = 8'h75;
			3'd2: c = 8'h6E;
			3'd3: c = 8'h63;
			3'd4: c = 8'h74;
			3'd5: c = 8'h69;
			3'd6: c = 8'h6F;
			default: c = 8'h6E;
		endcase
		return c;
	endfunction

	function automatic word_t absorb(input word_t w, input logic [7:0] c);
		word_t r;
		r = w;
		if (c == CH_DOT && w.dots != 2'd2) begin
			r.dots = w.dots + 2'd1;
		end
		if (is_alpha(c)) begin
			r.saw_letter = 1'b1;
		end
		if (w.len >= FIELD_BITS'(2) || kw_if_char(w.len[2:0]) != c) begin
			r.alive[0] = 1'b0;
		end
		if (w.len >= FIELD_BITS'(4) || kw_else_char(w.len[2:0]) != c) begin
			r.alive[1] = 1'b0;
		end
		if (w.len >= FIELD_BITS'(8) || kw_fun_char(w.len[2:0]) != c) begin
			r.alive[2] = 1'b0;
		end
		if (w.len != LEN_MAX) begin
			r.len = w.len + FIELD_BITS'(1);
		end
		return r;
	endfunction

	function automatic tok_beat_t make_tok(input logic [4:0] kind,
			input logic [FIELD_BITS-1:0] start, input logic [FIELD_BITS-1:0] len,
			input logic [2:0] err, input logic last);
		tok_beat_t t;
		t.kind = kind;
		t.start_offset = start;
		t.length = len;
		t.error_code = err;
		t.last = last;
		return t;
	endfunction

	function automatic tok_beat_t finish_word(input word_t w,
			input logic [FIELD_BITS-1:0] start);
		logic [4:0] kind;
		logic [2:0] err;
		kind = KIND_END;
		err = ERR_NONE;
		if (w.saw_letter) begin
			if (w.dots != 2'd0) begin
				err = ERR_DOTTED_IDENT;
			end else if (w.alive[0] && w.len == FIELD_BITS'(2)) begin
				kind = KIND_IF;
			end else if (w.alive[2] && w.len == FIELD_BITS'(8)) begin
				kind = KIND_FUNCTION;
			end else if (w.alive[1] && w.len == FIELD_BITS'(4)) begin
				kind = KIND_ELSE;
			end else begin
				kind = KIND_IDENT;
			end
		end else if (w.dots > 2'd1) begin
			err = ERR_EXTRA_DOTS;
		end else begin
			kind = KIND_NUMBER;
		end
		return make_tok(kind, start, w.len, err, 1'b0);
	endfunction

endpackage

>>> sv/tl_core.sv
// Lexer state registers and the per-beat next-state and token logic.
module tl_core (
	input logic clk,
	input logic arst_n,
	input logic go,
	input tl_pkg::src_beat_t beat,
	output tl_pkg::tl_emit_t emit
);
	import tl_pkg::*;

	localparam logic [2:0] MODE_IDLE = 3'd0;
	localparam logic [2:0] MODE_WORD = 3'd1;
	localparam logic [2:0] MODE_LT = 3'd2;
	localparam logic [2:0] MODE_STR = 3'd3;
	localparam logic [2:0] MODE_ERR = 3'd4;

	logic [2:0] mode_q, mode_n;
	logic [OFFSET_BITS-1:0] pos_q, pos_n;
	logic [OFFSET_BITS-1:0] tb_q, tb_n;
	word_t word_q, word_n;

	always_comb begin
		logic [1:0] cnt;
		logic do_begin;
		logic [7:0] c;
		logic [4:0] pk;
		tok_beat_t t0;
		tok_beat_t t1;
		tok_beat_t xt;
		mode_n = mode_q;
		pos_n = pos_q;
		tb_n = tb_q;
		word_n = word_q;
		cnt = 2'd0;
		do_begin = 1'b0;
		c = beat.ch;
		pk = punct_kind(c);
		t0 = '0;
		t1 = '0;
		xt = '0;
		if (beat.action == ACT_END) begin
			unique case (mode_q)
				MODE_WORD: begin
					t0 = finish_word(word_q, FIELD_BITS'(tb_q));
					cnt = 2'd1;
				end
				MODE_LT: begin
					t0 = make_tok(KIND_LT, FIELD_BITS'(tb_q), FIELD_BITS'(1), ERR_NONE, 1'b0);
					cnt = 2'd1;
				end
				MODE_STR: begin
					t0 = make_tok(KIND_END, FIELD_BITS'(tb_q), word_q.len, ERR_OPEN_STRING,
						1'b0);
					cnt = 2'd1;
				end
				default: begin
					cnt = 2'd0;
				end
			endcase
			xt = make_tok(KIND_END, FIELD_BITS'(pos_q), '0, ERR_NONE, 1'b1);
			if (cnt == 2'd0) begin
				t0 = xt;
			end else begin
				t1 = xt;
			end
			cnt = cnt + 2'd1;
			mode_n = MODE_IDLE;
			pos_n = '0;
			tb_n = '0;
			word_n = WORD_RESET;
		end else begin
			unique case (mode_q)
				MODE_WORD: begin
					if (is_word_char(c)) begin
						word_n = absorb(word_q, c);
					end else begin
						t0 = finish_word(word_q, FIELD_BITS'(tb_q));
						cnt = 2'd1;
						if (t0.error_code != ERR_NONE) begin
							mode_n = MODE_ERR;
						end else begin
							do_begin = 1'b1;
						end
					end
				end
				MODE_LT: begin
					cnt = 2'd1;
					if (c == CH_MINUS) begin
						mode_n = MODE_IDLE;
						t0 = make_tok(KIND_ASSIGN, FIELD_BITS'(tb_q), FIELD_BITS'(2), ERR_NONE,
							1'b0);
					end else begin
						t0 = make_tok(KIND_LT, FIELD_BITS'(tb_q), FIELD_BITS'(1), ERR_NONE,
							1'b0);
						do_begin = 1'b1;
					end
				end
				MODE_STR: begin
					if (c == CH_QUOTE) begin
						mode_n = MODE_IDLE;
						t0 = make_tok(KIND_STRING, FIELD_BITS'(tb_q), word_q.len, ERR_NONE,
							1'b0);
						cnt = 2'd1;
					end else if (word_q.len != LEN_MAX) begin
						word_n.len = word_q.len + FIELD_BITS'(1);
					end
				end
				MODE_ERR: begin
					mode_n = MODE_ERR;
				end
				default: begin
					do_begin = 1'b1;
				end
			endcase
			if (do_begin) begin
				mode_n = MODE_IDLE;
				xt = '0;
				if (is_space(c)) begin
					mode_n = MODE_IDLE;
				end else if (pk != KIND_END) begin
					xt = make_tok(pk, FIELD_BITS'(pos_q), FIELD_BITS'(1), ERR_NONE, 1'b0);
				end else if (c == CH_LT) begin
					mode_n = MODE_LT;
					tb_n = pos_q;
				end else if (c == CH_QUOTE) begin
					mode_n = MODE_STR;
					tb_n = pos_q + OFFSET_BITS'(1);
					word_n.len = '0;
				end else if (is_word_char(c)) begin
					mode_n = MODE_WORD;
					tb_n = pos_q;
					word_n = absorb(WORD_RESET, c);
				end else begin
					mode_n = MODE_ERR;
					xt = make_tok(KIND_END, FIELD_BITS'(pos_q), FIELD_BITS'(1), ERR_BAD_CHAR,
						1'b0);
				end
				if (xt.length != '0) begin
					if (cnt == 2'd0) begin
						t0 = xt;
					end else begin
						t1 = xt;
					end
					cnt = cnt + 2'd1;
				end
			end
			pos_n = pos_q + OFFSET_BITS'(1);
		end
		emit.count = cnt;
		emit.first = t0;
		emit.second = t1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pos_q <= '0;
			tb_q <= '0;
			word_q <= WORD_RESET;
		end else if (go) begin
			mode_q <= mode_n;
			pos_q <= pos_n;
			tb_q <= tb_n;
			word_q <= word_n;
		end
	end

endmodule

>>> sv/tl_outq.sv
// Two-slot token output queue; the front slot drives the token channel.
module tl_outq (
	input logic clk,
	input logic arst_n,
	input logic push,
	input tl_pkg::tl_emit_t emit,
	input logic tok_stall,
	output logic tok_valid,
	output tl_pkg::tok_beat_t tok_beat,
	output logic room
);
	import tl_pkg::*;

	logic v0_q, v1_q;
	tok_beat_t r0_q, r1_q;
	logic pop;

	assign pop = v0_q && !tok_stall;
	assign room = !v1_q && (!v0_q || pop);
	assign tok_valid = v0_q;
	assign tok_beat = r0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else if (push) begin
			v0_q <= emit.count != 2'd0;
			v1_q <= emit.count == 2'd2;
		end else if (pop) begin
			v0_q <= v1_q;
			v1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			r0_q <= emit.first;
			r1_q <= emit.second;
		end else if (pop) begin
			r0_q <= r1_q;
		end
	end

endmodule

>>> sv/token_lexer.sv
// Top level of the streaming token lexer: input register, lexer core and output queue.
//
//  Channel | Direction | Payload     | Handshake
//  src     | in        | src_beat_t  | src_valid, src_stall
//  tok     | out       | tok_beat_t  | tok_valid, tok_stall
//
// One source beat is taken per cycle while src_stall is low. A beat is held in the
// input register, and its tokens are written into the output queue when there is room.
// After a beat that yields two tokens, the next beat is held in the input register
// until the second slot of the two-slot output queue is empty.
// Reset clears the lexer state and the valid flags of the input register and queue.
// A stall on the token side backs up into src_stall as soon as a token waits in the
// front output slot.
module token_lexer (
	input logic clk,
	input logic arst_n,
	input logic src_valid,
	output logic src_stall,
	input tl_pkg::src_beat_t src_beat,
	output logic tok_valid,
	input logic tok_stall,
	output tl_pkg::tok_beat_t tok_beat
);
	import tl_pkg::*;

	logic valid_s1;
	src_beat_t beat_s1;
	logic room;
	logic advance;
	tl_emit_t emit;

	assign advance = valid_s1 && room;
	assign src_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!src_stall && src_valid) begin
			beat_s1 <= src_beat;
		end
	end

	tl_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.go(advance),
		.beat(beat_s1),
		.emit(emit)
	);

	tl_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(advance),
		.emit(emit),
		.tok_stall(tok_stall),
		.tok_valid(tok_valid),
		.tok_beat(tok_beat),
		.room(room)
	);

endmodule

>>> sv/token_lexer_chk.sv
// Port-level checker for the token lexer and its bind to the top level.
module token_lexer_chk (
	input logic clk,
	input logic arst_n,
	input logic src_valid,
	input logic src_stall,
	input tl_pkg::src_beat_t src_beat,
	input logic tok_valid,
	input logic tok_stall,
	input tl_pkg::tok_beat_t tok_beat
);
	import tl_pkg::*;

	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid && $stable(tok_beat))
		else $error("Token beat changed while stalled.");

	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> tok_valid)
		else $error("Source stalled with no token waiting.");

	a_last_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_beat.last |-> tok_beat.kind == KIND_END &&
			tok_beat.error_code == ERR_NONE && tok_beat.length == '0)
		else $error("Closing beat is not a clean END.");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_beat.error_code != ERR_NONE |-> tok_beat.kind == KIND_END &&
			!tok_beat.last)
		else $error("Error beat has a token kind or the last flag.");

endmodule

bind token_lexer token_lexer_chk u_chk (.*);

>>> tb/sv/token_lexer_checker.sv
// Checker for the token lexer: predicts the token beats of each source beat and compares them.
module token_lexer_checker (
	input logic clk,
	input logic arst_n,
	input logic src_valid,
	input logic src_stall,
	input tl_pkg::src_beat_t src_beat,
	input logic tok_valid,
	input logic tok_stall,
	input tl_pkg::tok_beat_t tok_beat,
	output int mismatches,
	output int pending,
	output int tokens_checked,
	output int error_tokens
);
	timeunit 1ns;
	timeprecision 1ps;
	import tl_pkg::*;

	typedef enum logic [2:0] {SCAN_IDLE, SCAN_WORD, SCAN_LT, SCAN_STR, SCAN_DEAD} scan_t;

	scan_t scan;
	logic [OFFSET_BITS-1:0] here;
	logic [FIELD_BITS-1:0] tok_from;
	logic [FIELD_BITS-1:0] tok_len;
	logic [1:0] dot_seen;
	logic letter_seen;
	string word_text;
	tok_beat_t token_q[$];
	int fail_count;
	int seen_count;
	int err_count;

	function automatic logic letter_byte(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic digit_byte(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic blank_byte(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic word_byte(input logic [7:0] c);
		return letter_byte(c) || digit_byte(c) || c == CH_DOT;
	endfunction

	function automatic logic [4:0] punct_code(input logic [7:0] c);
		logic [4:0] k;
		k = KIND_END;
		case (c)
			"(": k = KIND_LPAREN;
			")": k = KIND_RPAREN;
			"{": k = KIND_LBRACE;
			"}": k = KIND_RBRACE;
			"[": k = KIND_LBRACKET;
			"]": k = KIND_RBRACKET;
			"+": k = KIND_PLUS;
			"-": k = KIND_MINUS;
			"/": k = KIND_SLASH;
			"=": k = KIND_EQUAL;
			"*": k = KIND_STAR;
			";": k = KIND_SEMI;
			",": k = KIND_COMMA;
			default: k = KIND_END;
		endcase
		return k;
	endfunction

	task automatic expect_token(input logic [4:0] kind, input logic [FIELD_BITS-1:0] start,
			input logic [FIELD_BITS-1:0] len, input logic [2:0] err, input logic last);
		tok_beat_t t;
		t.kind = kind;
		t.start_offset = start;
		t.length = len;
		t.error_code = err;
		t.last = last;
		token_q.push_back(t);
	endtask

	task automatic clear_scan();
		scan = SCAN_IDLE;
		here = '0;
		tok_from = '0;
		tok_len = '0;
		dot_seen = '0;
		letter_seen = 1'b0;
		word_text = "";
	endtask

	task automatic take_word_byte(input logic [7:0] c);
		if (c == CH_DOT && dot_seen != 2'd2) begin
			dot_seen = dot_seen + 2'd1;
		end
		if (letter_byte(c)) begin
			letter_seen = 1'b1;
		end
		if (word_text.len() < 9) begin
			word_text = $sformatf("%s%c", word_text, c);
		end
		if (tok_len != LEN_MAX) begin
			tok_len = tok_len + 1'b1;
		end
	endtask

	task automatic close_word();
		logic [4:0] kind;
		if (letter_seen && dot_seen != 2'd0) begin
			expect_token(KIND_END, tok_from, tok_len, ERR_DOTTED_IDENT, 1'b0);
			scan = SCAN_DEAD;
		end else if (!letter_seen && dot_seen > 2'd1) begin
			expect_token(KIND_END, tok_from, tok_len, ERR_EXTRA_DOTS, 1'b0);
			scan = SCAN_DEAD;
		end else begin
			if (!letter_seen) begin
				kind = KIND_NUMBER;
			end else if (word_text == "if") begin
				kind = KIND_IF;
			end else if (word_text == "else") begin
				kind = KIND_ELSE;
			end else if (word_text == "function") begin
				kind = KIND_FUNCTION;
			end else begin
				kind = KIND_IDENT;
			end
			expect_token(kind, tok_from, tok_len, ERR_NONE, 1'b0);
			scan = SCAN_IDLE;
		end
	endtask

	task automatic open_token(input logic [7:0] c);
		logic [4:0] k;
		k = punct_code(c);
		scan = SCAN_IDLE;
		if (!blank_byte(c)) begin
			if (k != KIND_END) begin
				expect_token(k, here, FIELD_BITS'(1), ERR_NONE, 1'b0);
			end else if (c == CH_LT) begin
				scan = SCAN_LT;
				tok_from = here;
			end else if (c == CH_QUOTE) begin
				scan = SCAN_STR;
				tok_from = here + 1'b1;
				tok_len = '0;
			end else if (word_byte(c)) begin
				scan = SCAN_WORD;
				tok_from = here;
				tok_len = '0;
				dot_seen = '0;
				letter_seen = 1'b0;
				word_text = "";
				take_word_byte(c);
			end else begin
				scan = SCAN_DEAD;
				expect_token(KIND_END, here, FIELD_BITS'(1), ERR_BAD_CHAR, 1'b0);
			end
		end
	endtask

	task automatic predict_beat(input src_beat_t b);
		if (b.action == ACT_END) begin
			case (scan)
				SCAN_WORD: close_word();
				SCAN_LT: expect_token(KIND_LT, tok_from, FIELD_BITS'(1), ERR_NONE, 1'b0);
				SCAN_STR: expect_token(KIND_END, tok_from, tok_len, ERR_OPEN_STRING, 1'b0);
				default: ;
			endcase
			expect_token(KIND_END, here, '0, ERR_NONE, 1'b1);
			clear_scan();
		end else begin
			case (scan)
				SCAN_WORD: begin
					if (word_byte(b.ch)) begin
						take_word_byte(b.ch);
					end else begin
						close_word();
						if (scan != SCAN_DEAD) begin
							open_token(b.ch);
						end
					end
				end
				SCAN_LT: begin
					if (b.ch == CH_MINUS) begin
						scan = SCAN_IDLE;
						expect_token(KIND_ASSIGN, tok_from, FIELD_BITS'(2), ERR_NONE, 1'b0);
					end else begin
						expect_token(KIND_LT, tok_from, FIELD_BITS'(1), ERR_NONE, 1'b0);
						open_token(b.ch);
					end
				end
				SCAN_STR: begin
					if (b.ch == CH_QUOTE) begin
						scan = SCAN_IDLE;
						expect_token(KIND_STRING, tok_from, tok_len, ERR_NONE, 1'b0);
					end else if (tok_len != LEN_MAX) begin
						tok_len = tok_len + 1'b1;
					end
				end
				SCAN_DEAD: ;
				default: open_token(b.ch);
			endcase
			here = here + 1'b1;
		end
	endtask

	task automatic report(input string what);
		fail_count++;
		if (fail_count <= 40) begin
			$display("[%0t] token beat %0d: %s", $time, seen_count, what);
		end
	endtask

	task automatic check_token(input tok_beat_t got);
		tok_beat_t want;
		seen_count++;
		if (got.error_code != ERR_NONE) begin
			err_count++;
		end
		if (token_q.size() == 0) begin
			report($sformatf("unexpected beat kind %0d start %0d", got.kind,
				got.start_offset));
		end else begin
			want = token_q.pop_front();
			if (got.kind !== want.kind) begin
				report($sformatf("kind %0d, predicted %0d", got.kind, want.kind));
			end
			if (got.start_offset !== want.start_offset) begin
				report($sformatf("start_offset %0d, predicted %0d", got.start_offset,
					want.start_offset));
			end
			if (got.length !== want.length) begin
				report($sformatf("length %0d, predicted %0d", got.length, want.length));
			end
			if (got.error_code !== want.error_code) begin
				report($sformatf("error_code %0d, predicted %0d", got.error_code,
					want.error_code));
			end
			if (got.last !== want.last) begin
				report($sformatf("last %0b, predicted %0b", got.last, want.last));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			token_q.delete();
		end else begin
			if (src_valid && !src_stall) begin
				predict_beat(src_beat);
			end
			if (tok_valid && !tok_stall) begin
				check_token(tok_beat);
			end
		end
		mismatches <= fail_count;
		pending <= token_q.size();
		tokens_checked <= seen_count;
		error_tokens <= err_count;
	end

endmodule

>>> tb/sv/token_lexer_tb.sv
// Testbench top for the token lexer: clock, reset, source text, token-side stalls and verdict.
module token_lexer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tl_pkg::*;

	localparam int TARGET_BEATS = 1400;
	localparam int CALM_FROM = 1150;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;

	logic clk;
	logic arst_n;
	logic src_valid;
	logic src_stall;
	src_beat_t src_beat;
	logic tok_valid;
	logic tok_stall;
	tok_beat_t tok_beat;

	int mismatches;
	int pending;
	int tokens_checked;
	int error_tokens;
	int beats_sent;
	int lines_sent;
	int gap_odds;
	int stall_odds;
	int idle_cycles;
	bit quiet;
	src_beat_t line_q[$];

	string kw_names[3] = '{"if", "else", "function"};
	string near_names[10] = '{"iff", "i", "elsa", "elxe", "els", "fuxction", "functiom",
		"funct", "fi", "IF"};
	string punct_set = "(){}[]+-/=*;,";
	logic [7:0] blank_set[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

	token_lexer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_beat(src_beat),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_beat(tok_beat)
	);

	token_lexer_checker u_tok_check (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_beat(src_beat),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok_beat(tok_beat),
		.mismatches(mismatches),
		.pending(pending),
		.tokens_checked(tokens_checked),
		.error_tokens(error_tokens)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_odds();
		int r;
		r = $urandom_range(0, 2);
		return (r == 0) ? 0 : (r == 1) ? 8 : 30;
	endfunction

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'h61 + 8'(r) : 8'h41 + 8'(r - 26);
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'h30 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_blank();
		return blank_set[$urandom_range(0, 5)];
	endfunction

	task automatic push_ch(input logic [7:0] c);
		src_beat_t b;
		b.action = ACT_BYTE;
		b.ch = c;
		line_q.push_back(b);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			push_ch(s[i]);
		end
	endtask

	task automatic push_end();
		src_beat_t b;
		b.action = ACT_END;
		b.ch = 8'($urandom_range(0, 255));
		line_q.push_back(b);
	endtask

	task automatic add_token();
		int n;
		logic [7:0] c;
		case ($urandom_range(0, 15))
			0: push_text(kw_names[$urandom_range(0, 2)]);
			1: push_text(near_names[$urandom_range(0, 9)]);
			2, 3, 14, 15: begin
				push_ch(rand_letter());
				n = $urandom_range(0, 6);
				repeat (n) push_ch(($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter());
			end
			4: begin
				n = $urandom_range(1, 5);
				repeat (n) push_ch(rand_digit());
			end
			5, 6: push_ch(punct_set[$urandom_range(0, 12)]);
			7: push_ch(CH_LT);
			8: begin
				push_ch(CH_LT);
				push_ch(CH_MINUS);
			end
			9, 10: begin
				push_ch(CH_QUOTE);
				n = $urandom_range(0, 6);
				repeat (n) begin
					c = 8'($urandom_range(0, 255));
					push_ch((c == CH_QUOTE) ? 8'h27 : c);
				end
				push_ch(CH_QUOTE);
			end
			11: begin
				push_ch(rand_digit());
				push_ch(CH_DOT);
				n = $urandom_range(0, 3);
				repeat (n) push_ch(rand_digit());
			end
			12: begin
				n = $urandom_range(1, 6);
				repeat (n) begin
					case ($urandom_range(0, 4))
						0: push_ch(rand_letter());
						4: push_ch(CH_DOT);
						default: push_ch(rand_digit());
					endcase
				end
			end
			default: begin
				if ($urandom_range(0, 3) == 0) begin
					push_ch(8'($urandom_range(0, 255)));
				end else begin
					push_ch(rand_blank());
				end
			end
		endcase
		if ($urandom_range(0, 9) < 6) begin
			push_ch(rand_blank());
		end
	endtask

	task automatic close_line();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			push_ch(CH_QUOTE);
			repeat ($urandom_range(0, 3)) push_ch(rand_letter());
		end else if (r == 1) begin
			push_ch(CH_LT);
		end
		push_end();
	endtask

	task automatic send_beat(input src_beat_t b);
		int gap;
		if (!quiet && $urandom_range(0, 99) < gap_odds) begin
			gap = $urandom_range(1, 14);
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_beat <= b;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		beats_sent++;
	endtask

	task automatic send_line();
		gap_odds = pick_odds();
		stall_odds = pick_odds();
		foreach (line_q[i]) begin
			send_beat(line_q[i]);
		end
		line_q.delete();
		lines_sent++;
		quiet = (beats_sent >= CALM_FROM);
	endtask

	initial begin
		tok_stall = 1'b0;
		forever begin
			repeat ($urandom_range(1, 24)) @(posedge clk);
			if (!quiet && $urandom_range(0, 99) < stall_odds) begin
				tok_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				tok_stall <= 1'b0;
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((src_valid && !src_stall) || (tok_valid && !tok_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int n;
		arst_n = 1'b0;
		src_valid = 1'b0;
		src_beat = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		push_text("if<-elze;");
		push_end();
		send_line();
		push_ch(CH_QUOTE);
		push_ch(8'hFF);
		push_ch(CH_QUOTE);
		push_ch(8'h20);
		push_ch(8'h00);
		push_ch(8'h39);
		push_end();
		send_line();
		push_text("1..2");
		push_end();
		send_line();
		push_ch(CH_LT);
		push_end();
		send_line();
		push_ch(CH_QUOTE);
		push_ch(8'h71);
		push_end();
		send_line();

		while (beats_sent < TARGET_BEATS) begin
			n = $urandom_range(0, 12);
			repeat (n) add_token();
			close_line();
			send_line();
		end
		src_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Lexed %0d source beats in %0d inputs; %0d token beats checked, %0d with errors.",
			beats_sent, lines_sent, tokens_checked, error_tokens);
		if (mismatches == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
